// File: sv/rgb_to_ascii_art_tiles_defines.svh
// Assertion macros shared by the ASCII art tile converter modules.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef RGB_TO_ASCII_ART_TILES_DEFINES_SVH
`define RGB_TO_ASCII_ART_TILES_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBAA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGBAA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rgbaa_pkg.sv
// Shared types and constants of the ASCII art tile converter.
// Used by rgbaa_colmem, rgbaa_div and rgb_to_ascii_art_tiles; no dependencies.
package rgbaa_pkg;

    localparam int SUM_W = 21;
    localparam int CNT_W = 13;
    localparam int LUM_W = 8;
    localparam int GLYPH_W = 7;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W = 3;

    localparam logic [GLYPH_W-1:0] NEWLINE = 7'd10;

    // Dark to light, first glyph in the top byte.
    localparam logic [559:0] GLYPH_RAMP =
        "$@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!lI;:,\"^`'. ";

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_OUT_COLUMNS  = 3'd2,
        CFG_HORIZ_SCALE  = 3'd3,
        CFG_VERT_SCALE   = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_EMIT_GLYPH,
        S_EMIT_NEWLINE
    } state_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } acc_t;

    typedef struct packed {
        logic rd_en;
        logic rd_fresh;   // read returns zero: the column store is cleared at this edge
        logic clear_all;
        logic wr_en;
        logic wr_valid;
    } mem_ctrl_t;

endpackage

// File: sv/rgbaa_colmem.sv
// Per-column accumulator store: a synchronous RAM of sums and counts plus valid bits.
// Depends on rgbaa_pkg and rgb_to_ascii_art_tiles_defines.svh.
`include "rgb_to_ascii_art_tiles_defines.svh"

module rgbaa_colmem #(
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rgbaa_pkg::mem_ctrl_t ctrl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  rgbaa_pkg::acc_t   wr_data,
    output rgbaa_pkg::acc_t   rd_data
);

    rgbaa_pkg::acc_t mem [DEPTH];
    rgbaa_pkg::acc_t rd_raw_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                valid_reg[wr_addr] <= ctrl.wr_valid;
            end
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= !ctrl.rd_fresh && valid_reg[rd_addr];
            end
        end
    end

    // An entry never written since the last clear reads as an empty accumulator.
    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

    `RGBAA_ASSERT_NEXT(a_clear_empties, ctrl.clear_all, valid_reg == '0,
        "column store not empty after clear")
    `RGBAA_ASSERT_NEXT(a_fresh_read_zero, ctrl.rd_en && ctrl.rd_fresh, !rd_valid_reg,
        "fresh read returned stale data")
    `RGBAA_ASSERT_NOW(a_no_write_on_clear, ctrl.clear_all, !ctrl.wr_en,
        "write collides with clear")

endmodule

// File: sv/rgbaa_div.sv
// Restoring divider for the tile average, one quotient bit per cycle.
// Depends on rgbaa_pkg and rgb_to_ascii_art_tiles_defines.svh.
`include "rgb_to_ascii_art_tiles_defines.svh"

module rgbaa_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rgbaa_pkg::SUM_W-1:0] dividend,
    input  logic [rgbaa_pkg::CNT_W-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [rgbaa_pkg::SUM_W-1:0] quotient
);

    localparam int QW = rgbaa_pkg::SUM_W;
    localparam int RW = rgbaa_pkg::CNT_W + 1;
    localparam int NW = $clog2(QW + 1);

    logic [QW-1:0] quot_reg, quot_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [rgbaa_pkg::CNT_W-1:0] div_reg;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW-1:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg[RW-2:0], quot_reg[QW-1]};
        quot_next = {quot_reg[QW-2:0], 1'b0};
        rem_next  = shifted;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next     = shifted - {1'b0, div_reg};
                quot_next[0] = 1'b1;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= NW'(QW);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

    `RGBAA_ASSERT_NOW(a_no_restart, start, !busy_reg, "divider restarted while busy")
    `RGBAA_ASSERT_NEXT(a_done_ends_busy, busy_reg && cnt_reg == NW'(1), done_reg && !busy_reg,
        "divider did not finish on its last step")
    `RGBAA_ASSERT_NOW(a_nonzero_divisor, start, divisor != '0, "division by zero count")

endmodule

// File: sv/rgb_to_ascii_art_tiles.sv
// Top level of the RGB to ASCII art tile converter: tile position, control and output word.
// Depends on rgbaa_pkg, rgbaa_colmem, rgbaa_div and rgb_to_ascii_art_tiles_defines.svh.
//
// Pixels enter in raster order; each pixel in a tile adds its luminance into the accumulator
// RAM entry of its output column by read-modify-write. A pixel outside every tile leaves the
// block idle. A pixel inside a tile is read from the RAM as it is accepted and written back
// in the update state before the next accept. A pixel that finishes a tile also runs the
// serial divider for the average and then hands out its glyph, and a newline after the last
// column, before the next accept; output back-pressure can hold this longer. The accumulators
// clear at once at a frame start and at the end of an image, so no clearing pass is needed.
`include "rgb_to_ascii_art_tiles_defines.svh"

module rgb_to_ascii_art_tiles #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_IMAGE_DIM = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
    input  logic        s_axis_tuser,  // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // glyph [6:0], zero fill [7]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [rgbaa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbaa_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = $clog2(MAX_IMAGE_DIM);
    localparam int DW = $clog2(MAX_IMAGE_DIM + 1);
    localparam int WIDE = (DW > 13) ? DW : 13;
    localparam int OW = DW + 9;
    localparam int EW = DW + 2;
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int CWIDE = (CW > 9) ? CW : 9;
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Configuration registers.
    logic [12:0] image_width_reg, image_height_reg;
    logic [8:0]  out_columns_reg;
    logic [13:0] horiz_scale_reg;
    logic [14:0] vert_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 13'd640;
            image_height_reg <= 13'd480;
            out_columns_reg  <= 9'd120;
            horiz_scale_reg  <= 14'd1365;
            vert_scale_reg   <= 15'd2457;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rgbaa_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[12:0];
                rgbaa_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[12:0];
                rgbaa_pkg::CFG_OUT_COLUMNS:  out_columns_reg  <= cfg_data[8:0];
                rgbaa_pkg::CFG_HORIZ_SCALE:  horiz_scale_reg  <= cfg_data[13:0];
                rgbaa_pkg::CFG_VERT_SCALE:   vert_scale_reg   <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Clamped working values.
    logic [WIDE-1:0]  iw_wide, ih_wide;
    logic [CWIDE-1:0] oc_wide;
    logic [DW-1:0]    w, h;
    logic [CW-1:0]    cols;
    logic [13:0]      sx;
    logic [14:0]      sy;

    always_comb
    begin
        iw_wide = WIDE'(image_width_reg);
        ih_wide = WIDE'(image_height_reg);
        oc_wide = CWIDE'(out_columns_reg);
        if (iw_wide == '0)
            w = DW'(1);
        else if (iw_wide > WIDE'(MAX_IMAGE_DIM))
            w = DW'(MAX_IMAGE_DIM);
        else
            w = iw_wide[DW-1:0];
        if (ih_wide == '0)
            h = DW'(1);
        else if (ih_wide > WIDE'(MAX_IMAGE_DIM))
            h = DW'(MAX_IMAGE_DIM);
        else
            h = ih_wide[DW-1:0];
        if (oc_wide == '0)
            cols = CW'(1);
        else if (oc_wide > CWIDE'(MAX_COLUMNS))
            cols = CW'(MAX_COLUMNS);
        else
            cols = oc_wide[CW-1:0];
        sx = (horiz_scale_reg < 14'd256) ? 14'd256 : horiz_scale_reg;
        sy = (vert_scale_reg < 15'd256) ? 15'd256 : vert_scale_reg;
    end

    // Position state.
    logic [PW-1:0] pixel_col_reg, pixel_col_next;
    logic [PW-1:0] pixel_row_reg, pixel_row_next;
    logic [OW-1:0] band_origin_reg, band_origin_next;
    logic [CW-1:0] column_index_reg, column_index_next;
    logic [OW-1:0] column_origin_reg, column_origin_next;

    rgbaa_pkg::state_t state_reg, state_next;

    logic accept;
    logic fs;
    logic [PW-1:0] pc_e, pr_e;
    logic [OW-1:0] bo_e, co_e, next_origin;
    logic [CW-1:0] ci_e;
    logic [EW-1:0] xe, ye, by, bend, cx, cend, bend_raw, cend_raw, we, he;
    logic in_tile, hit_end, band_end, last_col, row_end, eoi;
    logic [rgbaa_pkg::LUM_W+16-1:0] lum_full;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign fs     = s_axis_tuser;

    always_comb
    begin
        pc_e = fs ? '0 : pixel_col_reg;
        pr_e = fs ? '0 : pixel_row_reg;
        bo_e = fs ? '0 : band_origin_reg;
        co_e = fs ? '0 : column_origin_reg;
        ci_e = fs ? '0 : column_index_reg;
        we   = EW'(w);
        he   = EW'(h);
        xe   = (EW'(pc_e) >= we) ? we - 1'b1 : EW'(pc_e);
        ye   = (EW'(pr_e) >= he) ? he - 1'b1 : EW'(pr_e);
        by   = EW'(bo_e[OW-1:8]);
        bend_raw = by + EW'(sy[14:8]);
        bend = (bend_raw > he) ? he : bend_raw;
        cx   = EW'(co_e[OW-1:8]);
        cend_raw = cx + EW'(sx[13:8]);
        cend = (cend_raw > we) ? we : cend_raw;
        in_tile  = (ye >= by) && (ye < bend) && (ci_e < cols) && (xe >= cx) && (xe < cend);
        hit_end  = (xe == cend - 1'b1);
        band_end = (ye == bend - 1'b1);
        next_origin = co_e + OW'(sx);
        last_col = (CW'(ci_e + 1'b1) >= cols) || (EW'(next_origin[OW-1:8]) >= we);
        row_end  = (xe + 1'b1 >= we);
        eoi      = row_end && (ye + 1'b1 >= he);

        column_index_next  = ci_e;
        column_origin_next = co_e;
        if (in_tile && hit_end)
        begin
            column_index_next  = ci_e + 1'b1;
            column_origin_next = next_origin;
        end
        band_origin_next = bo_e;
        pixel_row_next   = ye[PW-1:0];
        pixel_col_next   = PW'(xe + 1'b1);
        if (row_end)
        begin
            pixel_col_next     = '0;
            column_index_next  = '0;
            column_origin_next = '0;
            if ((ye >= by) && (ye + 1'b1 == bend))
                band_origin_next = bo_e + OW'(sy);
            if (eoi)
            begin
                pixel_row_next   = '0;
                band_origin_next = '0;
            end
            else
            begin
                pixel_row_next = PW'(ye + 1'b1);
            end
        end
        lum_full = 24'(s_axis_tdata[7:0]) * 24'd19595 + 24'(s_axis_tdata[15:8]) * 24'd38470
                 + 24'(s_axis_tdata[23:16]) * 24'd7471;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_col_reg     <= '0;
            pixel_row_reg     <= '0;
            band_origin_reg   <= '0;
            column_index_reg  <= '0;
            column_origin_reg <= '0;
        end
        else if (accept)
        begin
            pixel_col_reg     <= pixel_col_next;
            pixel_row_reg     <= pixel_row_next;
            band_origin_reg   <= band_origin_next;
            column_index_reg  <= column_index_next;
            column_origin_reg <= column_origin_next;
        end
    end

    // Per-item registers carried through the read-modify-write.
    logic [rgbaa_pkg::LUM_W-1:0] lum_reg;
    logic [AW-1:0] addr_reg;
    logic          emit_reg, last_col_reg, skip_wb_reg;
    logic [rgbaa_pkg::SUM_W-1:0] avg_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lum_reg      <= lum_full[23:16];
            addr_reg     <= ci_e[AW-1:0];
            emit_reg     <= hit_end && band_end;
            last_col_reg <= last_col;
            skip_wb_reg  <= eoi;
        end
    end

    // Column store and divider.
    rgbaa_pkg::mem_ctrl_t mem_ctrl;
    rgbaa_pkg::acc_t      rd_data, wr_data;
    logic div_start, div_busy, div_done;
    logic [rgbaa_pkg::SUM_W-1:0] quotient;

    assign wr_data = {rd_data.sum + rgbaa_pkg::SUM_W'(lum_reg), rd_data.count + 1'b1};

    rgbaa_colmem #(
        .DEPTH (MAX_COLUMNS),
        .AW    (AW)
    ) u_colmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mem_ctrl),
        .rd_addr (ci_e[AW-1:0]),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    rgbaa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wr_data.sum),
        .divisor  (wr_data.count),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            avg_reg <= quotient;
        end
    end

    // Glyph from the average: index = avg * 69 / 255.
    logic [7:0]  avg_clamp;
    logic [14:0] prod;
    logic [15:0] prod_adj;
    logic [6:0]  ramp_idx;
    logic [rgbaa_pkg::GLYPH_W-1:0] glyph;

    always_comb
    begin
        avg_clamp = (avg_reg > rgbaa_pkg::SUM_W'(255)) ? 8'd255 : avg_reg[7:0];
        prod      = 15'(avg_clamp) * 15'd69;
        prod_adj  = 16'(prod) + 16'd1 + 16'(prod[14:8]);
        ramp_idx  = 7'(prod_adj[15:8]);
        glyph     = rgbaa_pkg::GLYPH_RAMP[(7'd69 - ramp_idx) * 8 +: 7];
    end

    // Output word register.
    logic m_valid_reg, m_last_reg;
    logic [rgbaa_pkg::GLYPH_W-1:0] m_glyph_reg;
    logic out_free, load_glyph, load_newline;

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next   = state_reg;
        mem_ctrl     = '0;
        div_start    = 1'b0;
        load_glyph   = 1'b0;
        load_newline = 1'b0;
        case (state_reg)
            rgbaa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    mem_ctrl.rd_en     = in_tile;
                    mem_ctrl.rd_fresh  = fs;
                    mem_ctrl.clear_all = fs || eoi;
                    if (in_tile)
                        state_next = rgbaa_pkg::S_UPDATE;
                end
            end
            rgbaa_pkg::S_UPDATE:
            begin
                mem_ctrl.wr_en    = !skip_wb_reg;
                mem_ctrl.wr_valid = !emit_reg;
                if (emit_reg)
                begin
                    div_start  = 1'b1;
                    state_next = rgbaa_pkg::S_DIV;
                end
                else
                begin
                    state_next = rgbaa_pkg::S_IDLE;
                end
            end
            rgbaa_pkg::S_DIV:
            begin
                if (div_done)
                    state_next = rgbaa_pkg::S_EMIT_GLYPH;
            end
            rgbaa_pkg::S_EMIT_GLYPH:
            begin
                if (out_free)
                begin
                    load_glyph = 1'b1;
                    state_next = last_col_reg ? rgbaa_pkg::S_EMIT_NEWLINE : rgbaa_pkg::S_IDLE;
                end
            end
            rgbaa_pkg::S_EMIT_NEWLINE:
            begin
                if (out_free)
                begin
                    load_newline = 1'b1;
                    state_next   = rgbaa_pkg::S_IDLE;
                end
            end
            default: state_next = rgbaa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rgbaa_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_glyph || load_newline)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_glyph)
        begin
            m_glyph_reg <= glyph;
            m_last_reg  <= !last_col_reg;
        end
        else if (load_newline)
        begin
            m_glyph_reg <= rgbaa_pkg::NEWLINE;
            m_last_reg  <= 1'b1;
        end
    end

    assign s_axis_tready = (state_reg == rgbaa_pkg::S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_glyph_reg};
    assign m_axis_tlast  = m_last_reg;

    `RGBAA_ASSERT_NOW(a_div_only_in_div, div_busy,
        state_reg == rgbaa_pkg::S_DIV, "divider running outside the divide state")
    `RGBAA_ASSERT_NOW(a_no_lost_word, load_glyph || load_newline,
        !m_valid_reg || m_axis_tready, "output word overwritten before it was taken")
    `RGBAA_ASSERT_NEXT(a_newline_is_last, load_newline,
        m_axis_tlast && m_axis_tdata[6:0] == rgbaa_pkg::NEWLINE, "newline word not marked last")
    `RGBAA_ASSERT_NOW(a_glyph_index_range, state_reg == rgbaa_pkg::S_EMIT_GLYPH,
        ramp_idx <= 7'd69, "glyph index beyond the ramp")

endmodule

// File: test/testbench.sv
// Self-checking testbench for the RGB to ASCII art tile converter.
// Depends on rgbaa_pkg and rgb_to_ascii_art_tiles; a scoreboard class predicts glyph words.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rgbaa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef struct {
        logic [rgbaa_pkg::GLYPH_W-1:0] glyph;
        logic                          last;
    } glyph_word_t;

    class tile_scoreboard;
        int unsigned width_reg, height_reg, columns_reg, hscale_reg, vscale_reg;
        int unsigned col_sum[256];
        int unsigned col_cnt[256];
        int unsigned px_col, px_row, band_fix, col_idx, col_fix;
        glyph_word_t expected_glyphs[$];
        int errors;

        function new();
            width_reg = 640;
            height_reg = 480;
            columns_reg = 120;
            hscale_reg = 1365;
            vscale_reg = 2457;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (col_sum[i])
            begin
                col_sum[i] = 0;
                col_cnt[i] = 0;
            end
            px_col = 0;
            px_row = 0;
            band_fix = 0;
            col_idx = 0;
            col_fix = 0;
        endfunction

        function void write_reg(rgbaa_pkg::cfg_index_t idx,
                                logic [rgbaa_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                rgbaa_pkg::CFG_IMAGE_WIDTH:  width_reg = 32'(value[12:0]);
                rgbaa_pkg::CFG_IMAGE_HEIGHT: height_reg = 32'(value[12:0]);
                rgbaa_pkg::CFG_OUT_COLUMNS:  columns_reg = 32'(value[8:0]);
                rgbaa_pkg::CFG_HORIZ_SCALE:  hscale_reg = 32'(value[13:0]);
                rgbaa_pkg::CFG_VERT_SCALE:   vscale_reg = 32'(value[14:0]);
                default: ;
            endcase
        endfunction

        static function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                 logic frame_start);
            int unsigned w, h, cols, sx, sy, lum, x, y, by, bend, cx, cend, ci;
            int unsigned next_fix, cnt, avg, ramp_pos;
            bit last_col;
            glyph_word_t word;
            w = clamp(width_reg, 1, 4096);
            h = clamp(height_reg, 1, 4096);
            cols = clamp(columns_reg, 1, 256);
            sx = (hscale_reg < 256) ? 256 : hscale_reg;
            sy = (vscale_reg < 256) ? 256 : vscale_reg;
            lum = (19595 * red + 38470 * green + 7471 * blue) >> 16;
            if (frame_start)
                clear_frame();
            // A register change can leave the position outside a smaller image.
            if (px_col >= w) px_col = w - 1;
            if (px_row >= h) px_row = h - 1;
            x = px_col;
            y = px_row;
            by = band_fix >> 8;
            bend = by + (sy >> 8);
            if (bend > h) bend = h;
            if (y >= by && y < bend && col_idx < cols)
            begin
                cx = col_fix >> 8;
                cend = cx + (sx >> 8);
                if (cend > w) cend = w;
                if (x >= cx && x < cend)
                begin
                    ci = col_idx;
                    col_sum[ci] += lum;
                    col_cnt[ci] += 1;
                    if (x == cend - 1)
                    begin
                        next_fix = col_fix + sx;
                        last_col = (ci + 1 >= cols) || ((next_fix >> 8) >= w);
                        if (y == bend - 1)
                        begin
                            cnt = col_cnt[ci] ? col_cnt[ci] : 1;
                            avg = col_sum[ci] / cnt;
                            if (avg > 255) avg = 255;
                            ramp_pos = avg * 69 / 255;
                            word.glyph = rgbaa_pkg::GLYPH_RAMP[552 - 8 * ramp_pos +: 7];
                            word.last = !last_col;
                            expected_glyphs.push_back(word);
                            if (last_col)
                            begin
                                word.glyph = rgbaa_pkg::NEWLINE;
                                word.last = 1'b1;
                                expected_glyphs.push_back(word);
                            end
                            col_sum[ci] = 0;
                            col_cnt[ci] = 0;
                        end
                        col_idx = ci + 1;
                        col_fix = next_fix;
                    end
                end
            end
            if (x + 1 >= w)
            begin
                px_col = 0;
                col_idx = 0;
                col_fix = 0;
                if (y >= by && y + 1 == bend)
                    band_fix += sy;
                if (y + 1 >= h)
                    clear_frame();
                else
                    px_row = y + 1;
            end
            else
                px_col = x + 1;
        endfunction

        function void check_word(logic [7:0] data, logic last);
            glyph_word_t exp_word;
            if (expected_glyphs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: glyph %0d last %0b", data[6:0], last);
                return;
            end
            exp_word = expected_glyphs.pop_front();
            if (data !== {1'b0, exp_word.glyph} || last !== exp_word.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("word mismatch: expected glyph %0d last %0b, got %0d last %0b",
                             exp_word.glyph, exp_word.last, data, last);
            end
        endfunction

        function int pending();
            return expected_glyphs.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red [7:0], green [15:8], blue [23:16]
    logic        s_axis_tuser;   // frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // glyph [6:0], zero fill [7]
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [rgbaa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rgbaa_pkg::CFG_DATA_W-1:0] cfg_data;

    tile_scoreboard scoreboard = new();
    bit sender_no_gaps;
    bit receiver_no_stalls = 1'b0;
    int stall_left = 0;

    rgb_to_ascii_art_tiles dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_register(logic [rgbaa_pkg::CFG_IDX_W-1:0] idx,
                                  logic [rgbaa_pkg::CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        scoreboard.write_reg(rgbaa_pkg::cfg_index_t'(idx), value);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                              logic frame_start);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {blue, green, red};
        s_axis_tuser <= frame_start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        scoreboard.note_pixel(red, green, blue, frame_start);
        gap = sender_no_gaps ? 0 : gap_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_pixel(bit frame_start);
        logic [7:0] ch [3];
        foreach (ch[i])
            ch[i] = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                 : 8'($urandom);
        send_pixel(ch[0], ch[1], ch[2], frame_start);
    endtask

    // Lets the block settle so that a register write finds it idle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic run_phase(logic [rgbaa_pkg::CFG_DATA_W-1:0] w,
                             logic [rgbaa_pkg::CFG_DATA_W-1:0] h,
                             logic [rgbaa_pkg::CFG_DATA_W-1:0] cols,
                             logic [rgbaa_pkg::CFG_DATA_W-1:0] hs,
                             logic [rgbaa_pkg::CFG_DATA_W-1:0] vs, int count);
        write_register(rgbaa_pkg::CFG_IMAGE_WIDTH, w);
        write_register(rgbaa_pkg::CFG_IMAGE_HEIGHT, h);
        write_register(rgbaa_pkg::CFG_OUT_COLUMNS, cols);
        write_register(rgbaa_pkg::CFG_HORIZ_SCALE, hs);
        write_register(rgbaa_pkg::CFG_VERT_SCALE, vs);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                sender_no_gaps = !sender_no_gaps;
            send_random_pixel(i == 0 || $urandom_range(0, 59) == 0);
        end
        wait_drained();
    endtask

    // Output side: check accepted words, then choose the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            scoreboard.check_word(m_axis_tdata, m_axis_tlast);
        if ($urandom_range(0, 199) == 0)
            receiver_no_stalls = !receiver_no_stalls;
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!receiver_no_stalls && $urandom_range(0, 3) == 0)
                stall_left = gap_length();
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sender_no_gaps = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: 2x2 tiles on a 4x4 image, extreme colors and frame restarts.
        write_register(rgbaa_pkg::CFG_IMAGE_WIDTH, 15'd4);
        write_register(rgbaa_pkg::CFG_IMAGE_HEIGHT, 15'd4);
        write_register(rgbaa_pkg::CFG_OUT_COLUMNS, 15'd2);
        write_register(rgbaa_pkg::CFG_HORIZ_SCALE, 15'd512);
        write_register(rgbaa_pkg::CFG_VERT_SCALE, 15'd512);
        write_register(CFG_UNUSED_INDEX, 15'h7FFF);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        for (int i = 0; i < 7; i++)
            send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        for (int i = 0; i < 8; i++)
            send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b1);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        wait_drained();

        // Out-of-range values clamp: one-pixel image, single column, minimum scales.
        run_phase(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 30);
        // Widest image with the most columns.
        run_phase(15'h1FFF, 15'd2, 15'h1FF, 15'd256, 15'd256, 150);
        // Largest scales clip both spans at the image edge.
        run_phase(15'd10, 15'd9, 15'd3, 15'd16383, 15'd32767, 60);
        run_phase(15'd7, 15'd5, 15'd3, 15'd600, 15'd1080, 80);
        run_phase(15'd13, 15'd6, 15'd256, 15'd384, 15'd691, 80);
        run_phase(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 20);
        run_phase(15'd5, 15'd3, 15'd2, 15'd640, 15'd1152, 60);

        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/rgbaa_pkg.sv
sv/rgbaa_colmem.sv
sv/rgbaa_div.sv
sv/rgb_to_ascii_art_tiles.sv
test/testbench.sv
